[hw/rtl/fifo_queue_with_key_sort_core_macros.svh]
// Assertion macros used by the controller RTL of the queue.
`ifndef FIFO_QUEUE_WITH_KEY_SORT_CORE_MACROS_SVH
`define FIFO_QUEUE_WITH_KEY_SORT_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FQKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FQKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fqks_pkg.sv]
`default_nettype none
package fqks_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SORT   = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] start_time;
        logic [7:0]  proc_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_empty;
        logic [4:0]  entry_total;
        logic [15:0] head_start;
        logic [7:0]  head_tag;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SORT_I,
        S_LOADI,
        S_CMP,
        S_PLACE,
        S_RDHEAD,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic latch_item;
        logic exec;
        logic sort_rd_i;
        logic sort_load_i;
        logic sort_cmp;
        logic sort_place;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       sort_done;
        logic       key_gt;
        logic       j_one;
        logic       out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

[hw/rtl/fifo_queue_with_key_sort_core.sv]
// Append, remove and no-op: the operation executes, the head entry is read and the result is loaded.
// Sort of n entries: an insertion sort that shifts each entry from the second on left past strictly
// larger keys, at most n*(n-1)/2 shifts in all. Each result is loaded before the next transaction is
// accepted. A new transaction is accepted while a previous result is still waiting at the output.
// Synchronous active-low reset empties the queue and clears the control state at once;
// the entry memory is not cleared and no entry is read before it is written.
`default_nettype none
module fifo_queue_with_key_sort_core #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire fqks_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output fqks_pkg::t_out_item      o_item
);
    import fqks_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    fqks_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    fqks_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule
`default_nettype wire

[hw/rtl/fqks_dp.sv]
`default_nettype none
module fqks_dp #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fqks_pkg::t_in_item  i_item,
    input  wire fqks_pkg::t_dp_cmd   i_cmd,
    output fqks_pkg::t_dp_stat       o_stat,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output fqks_pkg::t_out_item      o_item
);
    import fqks_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_BITS + TAG_BITS;

    logic [EW-1:0] r_mem [CAPACITY];
    logic [EW-1:0] r_rd_data;
    logic [PW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx_i, n_idx_i;
    logic [PW-1:0] r_idx_j, n_idx_j;
    logic [EW-1:0] r_hold, n_hold;
    logic [1:0]    r_status, n_status;
    t_in_item      r_item;
    logic          r_out_valid;
    t_out_item     r_out;
    t_out_item     out_next;

    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] rd_addr;
    logic [EW-1:0] wr_data;
    logic [EW-1:0] new_entry;
    logic          key_gt;
    logic          out_free;
    logic          is_empty;

    // Maps a position in queue order to its place in the circular store.
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
                                           input logic [PW-1:0] ofs);
        logic [PW:0] sum;
        sum = {1'b0, head} + {1'b0, ofs};
        if (sum >= (PW+1)'(CAPACITY)) begin
            sum = sum - (PW+1)'(CAPACITY);
        end
        return sum[PW-1:0];
    endfunction

    assign new_entry = {KEY_BITS'(r_item.start_time), TAG_BITS'(r_item.proc_tag)};
    assign key_gt    = r_rd_data[EW-1:TAG_BITS] > r_hold[EW-1:TAG_BITS];
    assign out_free  = !r_out_valid || !i_stall;
    assign is_empty  = r_count == '0;

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_idx_i  = r_idx_i;
        n_idx_j  = r_idx_j;
        n_hold   = r_hold;
        n_status = r_status;
        wr_en    = 1'b0;
        wr_addr  = phys(r_head, r_idx_j);
        wr_data  = r_hold;
        rd_addr  = r_head;
        if (i_cmd.exec) begin
            case (r_item.op)
                OP_APPEND: begin
                    if (r_count == CW'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = phys(r_head, r_count[PW-1:0]);
                        wr_data  = new_entry;
                        n_count  = r_count + CW'(1);
                        n_status = ST_DONE;
                    end
                end
                OP_REMOVE: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_head   = phys(r_head, PW'(1));
                        n_count  = r_count - CW'(1);
                        n_status = ST_DONE;
                    end
                end
                OP_SORT: begin
                    n_idx_i  = CW'(1);
                    n_status = ST_DONE;
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
        if (i_cmd.sort_rd_i) begin
            rd_addr = phys(r_head, r_idx_i[PW-1:0]);
        end
        if (i_cmd.sort_load_i) begin
            n_hold  = r_rd_data;
            n_idx_j = r_idx_i[PW-1:0];
            rd_addr = phys(r_head, r_idx_i[PW-1:0] - PW'(1));
        end
        if (i_cmd.sort_cmp) begin
            wr_en = 1'b1;
            if (key_gt) begin
                wr_data = r_rd_data;
                n_idx_j = r_idx_j - PW'(1);
                rd_addr = phys(r_head, r_idx_j - PW'(2));
            end else begin
                n_idx_i = r_idx_i + CW'(1);
            end
        end
        if (i_cmd.sort_place) begin
            wr_en   = 1'b1;
            n_idx_i = r_idx_i + CW'(1);
        end
    end

    always_comb begin
        out_next.status      = r_status;
        out_next.is_empty    = is_empty;
        out_next.entry_total = 5'(r_count);
        out_next.head_start  = is_empty ? 16'd0 : 16'(r_rd_data[EW-1:TAG_BITS]);
        out_next.head_tag    = is_empty ? 8'd0 : 8'(r_rd_data[TAG_BITS-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx_i  <= n_idx_i;
        r_idx_j  <= n_idx_j;
        r_hold   <= n_hold;
        r_status <= n_status;
        if (i_cmd.latch_item) begin
            r_item <= i_item;
        end
        if (i_cmd.load_out) begin
            r_out <= out_next;
        end
    end

    assign o_stat.op        = r_item.op;
    assign o_stat.sort_done = r_idx_i >= r_count;
    assign o_stat.key_gt    = key_gt;
    assign o_stat.j_one     = r_idx_j == PW'(1);
    assign o_stat.out_free  = out_free;
    assign o_valid          = r_out_valid;
    assign o_item           = r_out;

endmodule
`default_nettype wire

[hw/rtl/fqks_ctrl.sv]
`default_nettype none
`include "fifo_queue_with_key_sort_core_macros.svh"
module fqks_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire fqks_pkg::t_dp_stat i_stat,
    output fqks_pkg::t_dp_cmd       o_cmd
);
    import fqks_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = (i_stat.op == OP_SORT) ? S_SORT_I : S_RDHEAD;
            end
            S_SORT_I: begin
                n_state = i_stat.sort_done ? S_RDHEAD : S_LOADI;
            end
            S_LOADI: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_stat.key_gt && i_stat.j_one) begin
                    n_state = S_PLACE;
                end else if (!i_stat.key_gt) begin
                    n_state = S_SORT_I;
                end
            end
            S_PLACE: begin
                n_state = S_SORT_I;
            end
            S_RDHEAD: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall          = 1'b0;
                o_cmd.latch_item = i_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_SORT_I: begin
                o_cmd.sort_rd_i = !i_stat.sort_done;
            end
            S_LOADI: begin
                o_cmd.sort_load_i = 1'b1;
            end
            S_CMP: begin
                o_cmd.sort_cmp = 1'b1;
            end
            S_PLACE: begin
                o_cmd.sort_place = 1'b1;
            end
            S_FINISH: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `FQKS_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_valid && !o_stall, r_state == S_EXEC, "accepted transaction was not executed")
    `FQKS_ASSERT_NOW(a_load_free, i_clk, i_rst_n, o_cmd.load_out, i_stat.out_free, "result loaded over a waiting result")
    `FQKS_ASSERT_NEXT(a_shift_last, i_clk, i_rst_n, r_state == S_CMP && i_stat.key_gt && i_stat.j_one, r_state == S_PLACE, "entry not placed at the head after the last shift")

endmodule
`default_nettype wire

[bench/fifo_queue_with_key_sort_core_checker.sv]
module fifo_queue_with_key_sort_core_checker
    import fqks_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    output int             o_mismatches,
    output int             o_outstanding,
    output int             o_items_taken,
    output int             o_results_seen,
    output int             o_full_drops,
    output int             o_empty_removes,
    output int             o_deep_sorts
);

    logic [15:0] key_model [CAPACITY];
    logic [7:0]  tag_model [CAPACITY];
    int          held_total;
    t_out_item   expected_status[$];

    task automatic report_failure(input string msg);
        $display("mismatch: %s", msg);
        o_mismatches++;
    endtask

    task automatic advance_queue(input t_in_item it, output t_out_item res);
        logic [15:0] k;
        logic [7:0]  t;
        int          i;
        int          j;
        res        = '0;
        res.status = ST_DONE;
        case (it.op)
            OP_APPEND: begin
                if (held_total >= CAPACITY) begin
                    res.status = ST_FULL;
                    o_full_drops++;
                end else begin
                    key_model[held_total] = it.start_time;
                    tag_model[held_total] = it.proc_tag;
                    held_total++;
                end
            end
            OP_REMOVE: begin
                if (held_total == 0) begin
                    res.status = ST_EMPTY;
                    o_empty_removes++;
                end else begin
                    for (i = 1; i < held_total; i++) begin
                        key_model[i - 1] = key_model[i];
                        tag_model[i - 1] = tag_model[i];
                    end
                    held_total--;
                end
            end
            OP_SORT: begin
                if (held_total >= 2) begin
                    o_deep_sorts++;
                end
                // Insertion sort; an entry only moves past strictly larger keys.
                for (i = 1; i < held_total; i++) begin
                    k = key_model[i];
                    t = tag_model[i];
                    j = i;
                    while (j > 0 && key_model[j - 1] > k) begin
                        key_model[j] = key_model[j - 1];
                        tag_model[j] = tag_model[j - 1];
                        j--;
                    end
                    key_model[j] = k;
                    tag_model[j] = t;
                end
            end
            default: begin
            end
        endcase
        res.is_empty    = (held_total == 0);
        res.entry_total = 5'(held_total);
        if (held_total > 0) begin
            res.head_start = key_model[0];
            res.head_tag   = tag_model[0];
        end
    endtask

    task automatic compare_result(input t_out_item got, input t_out_item want);
        if (got.status !== want.status) begin
            report_failure($sformatf("result %0d status got %0d expected %0d",
                o_results_seen, got.status, want.status));
        end
        if (got.is_empty !== want.is_empty) begin
            report_failure($sformatf("result %0d is_empty got %0d expected %0d",
                o_results_seen, got.is_empty, want.is_empty));
        end
        if (got.entry_total !== want.entry_total) begin
            report_failure($sformatf("result %0d entry_total got %0d expected %0d",
                o_results_seen, got.entry_total, want.entry_total));
        end
        if (got.head_start !== want.head_start) begin
            report_failure($sformatf("result %0d head_start got %0h expected %0h",
                o_results_seen, got.head_start, want.head_start));
        end
        if (got.head_tag !== want.head_tag) begin
            report_failure($sformatf("result %0d head_tag got %0h expected %0h",
                o_results_seen, got.head_tag, want.head_tag));
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item pred;
        if (!i_rst_n) begin
            held_total = 0;
            expected_status.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_status.size() == 0) begin
                    report_failure($sformatf("result %0d arrived with no transaction waiting",
                        o_results_seen));
                end else begin
                    want = expected_status.pop_front();
                    compare_result(i_out_item, want);
                end
                o_results_seen++;
            end
            if (i_in_valid && !i_in_stall) begin
                advance_queue(i_in_item, pred);
                expected_status.push_back(pred);
                o_items_taken++;
            end
        end
        o_outstanding = expected_status.size();
    end

endmodule

[bench/fifo_queue_with_key_sort_core_tb.sv]
module fifo_queue_with_key_sort_core_tb;
    import fqks_pkg::*;

    localparam int         CAPACITY       = 16;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         HOLD_CYCLES    = 300;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_request   = 1'b0;
    int   quiet_cycles   = 0;

    int mismatches;
    int outstanding;
    int items_taken;
    int results_seen;
    int full_drops;
    int empty_removes;
    int deep_sorts;

    fifo_queue_with_key_sort_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_stall(in_stall),
        .i_item (in_item),
        .o_valid(out_valid),
        .i_stall(out_stall),
        .o_item (out_item)
    );

    fifo_queue_with_key_sort_core_checker #(
        .CAPACITY(CAPACITY)
    ) checker_inst (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_item      (in_item),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_item     (out_item),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_items_taken  (items_taken),
        .o_results_seen (results_seen),
        .o_full_drops   (full_drops),
        .o_empty_removes(empty_removes),
        .o_deep_sorts   (deep_sorts)
    );

    initial begin
        forever begin
            #5 clk = ~clk;
        end
    end

    // The receiver stalls at random, and once holds off for a long stretch so the queue backs up.
    initial begin
        bit held_once;
        held_once = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request && !held_once) begin
                held_once = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", outstanding);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic push_op(input logic [1:0] op, input logic [15:0] key, input logic [7:0] tag);
        t_in_item it;
        it.op         = op;
        it.start_time = key;
        it.proc_tag   = tag;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        forever begin
            @(negedge clk);
            if (!in_stall) begin
                break;
            end
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic random_burst(input int count);
        int          mode;
        int          roll;
        int          append_cut;
        int          key_pick;
        logic [1:0]  op;
        logic [15:0] key;
        mode = 0;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                mode = $urandom_range(0, 2);
            end
            append_cut = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
            roll = $urandom_range(0, 99);
            if (roll < append_cut) begin
                op = OP_APPEND;
            end else if (roll < 85) begin
                op = OP_REMOVE;
            end else if (roll < 97) begin
                op = OP_SORT;
            end else begin
                op = OP_UNUSED;
            end
            key_pick = $urandom_range(0, 9);
            if (key_pick < 4) begin
                key = 16'($urandom_range(0, 7));
            end else if (key_pick == 4) begin
                key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end else begin
                key = 16'($urandom);
            end
            push_op(op, key, 8'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_op(OP_REMOVE, 16'h1234, 8'h56);
        push_op(OP_SORT, 16'h0000, 8'h00);
        push_op(OP_UNUSED, 16'hFFFF, 8'hFF);
        push_op(OP_APPEND, 16'hFFFF, 8'hFF);
        push_op(OP_SORT, 16'h0000, 8'h00);
        for (int n = 0; n < CAPACITY - 1; n++) begin
            case (n % 4)
                0: push_op(OP_APPEND, 16'h0000, 8'(n));
                1: push_op(OP_APPEND, 16'h0005, 8'(8'h80 + n));
                2: push_op(OP_APPEND, 16'hFFFF, 8'(8'h40 + n));
                default: push_op(OP_APPEND, 16'(16'h8000 - n), 8'(8'hF0 + n));
            endcase
        end
        push_op(OP_APPEND, 16'hAAAA, 8'hAA);
        push_op(OP_SORT, 16'h0000, 8'h00);
        push_op(OP_UNUSED, 16'h5555, 8'h55);
        push_op(OP_REMOVE, 16'h0000, 8'h00);

        send_idle_pct  = 25;
        recv_stall_pct = 49;
        random_burst(500);
        send_idle_pct  = 49;
        recv_stall_pct = 25;
        random_burst(500);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request  <= 1'b1;
        random_burst(500);
        in_valid <= 1'b0;

        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);

        $display("covered %0d transactions in and %0d results out, under both idle patterns",
            items_taken, results_seen);
        $display("with %0d sorts of two or more entries, %0d refused appends, %0d empty removals",
            deep_sorts, full_drops, empty_removes);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/fqks_pkg.sv
hw/rtl/fqks_dp.sv
hw/rtl/fqks_ctrl.sv
hw/rtl/fifo_queue_with_key_sort_core.sv
bench/fifo_queue_with_key_sort_core_checker.sv
bench/fifo_queue_with_key_sort_core_tb.sv
